/* hw/rtl/radix_string_to_integer_assert.svh */
// Assertion macros shared by the checker of the radix string converter
`ifndef RADIX_STRING_TO_INTEGER_ASSERT_SVH
`define RADIX_STRING_TO_INTEGER_ASSERT_SVH

// Same-cycle implication, off while reset is held
`define RSTOI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define RSTOI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rstoi_pkg.sv */
// Types, constants and digit decode for the radix string converter
package rstoi_pkg;

    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 8;
    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(16);
    localparam logic [RADIX_BITS-1:0] RADIX_AUTO  = RADIX_BITS'(0);
    localparam logic [RADIX_BITS-1:0] RADIX_OCT   = RADIX_BITS'(8);
    localparam logic [RADIX_BITS-1:0] RADIX_DEC   = RADIX_BITS'(10);
    localparam logic [RADIX_BITS-1:0] RADIX_HEX   = RADIX_BITS'(16);

    // digit codes
    localparam logic [CHAR_BITS-1:0] DIG_NONE = 8'hFF;
    localparam logic [CHAR_BITS-1:0] DIG_ZERO = 8'd0;
    localparam logic [CHAR_BITS-1:0] DIG_X    = 8'd33;

    // characters
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_BITS-1:0] UPPER_OFS = 8'd55;  // 'A' - 10
    localparam logic [CHAR_BITS-1:0] LOWER_OFS = 8'd87;  // 'a' - 10

    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 restart;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0] number;
        logic                  failed;
        logic [COUNT_BITS-1:0] consumed_length;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,  // leading blanks
        PH_SIGN   = 3'd1,  // sign taken
        PH_AUTO0  = 3'd2,  // leading 0 in auto mode
        PH_AUTOX  = 3'd3,  // first digit after 0x in auto mode
        PH_HEX0   = 3'd4,  // leading 0 in radix 16
        PH_DIGITS = 3'd5
    } t_phase;

    typedef struct packed {
        t_phase                phase;
        logic [VALUE_BITS-1:0] acc;
        logic [RADIX_BITS-1:0] active_radix;
        logic                  negative;
        logic                  error_seen;
        logic [COUNT_BITS-1:0] position;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:        PH_LEAD,
        acc:          '0,
        active_radix: '0,
        negative:     1'b0,
        error_seen:   1'b0,
        position:     '0
    };

    // character to digit value 0..35, DIG_NONE when not alphanumeric
    function automatic logic [CHAR_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] d;
        d = DIG_NONE;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = c - UPPER_OFS;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = c - LOWER_OFS;
        end
        return d;
    endfunction

endpackage

/* hw/rtl/rstoi_step.sv */
// Per-character state update and result generation of the converter
module rstoi_step (
    input  rstoi_pkg::t_in_item                 i_item,
    input  rstoi_pkg::t_state                   i_state,
    input  logic [rstoi_pkg::RADIX_BITS-1:0]    i_radix,
    output rstoi_pkg::t_state                   o_state,
    output logic                                o_emit,
    output rstoi_pkg::t_out_item                o_result
);
    import rstoi_pkg::*;

    localparam int PROD_W = VALUE_BITS + RADIX_BITS + 1;

    typedef enum logic [2:0] {
        P_BLANK,      // skip a blank
        P_SIGNCH,     // take a sign
        P_AUTO_ZERO,  // leading 0 in auto mode
        P_HEX_ZERO,   // leading 0 in radix 16
        P_XCH,        // x of an 0x prefix
        P_FIRST,      // first significant digit
        P_DIGIT       // digit or terminator
    } t_path;

    t_state                s;
    logic [CHAR_BITS-1:0]  c;
    logic [CHAR_BITS-1:0]  d;
    t_path                 path;
    t_phase                x_phase;
    logic [RADIX_BITS-1:0] af_r;
    logic [RADIX_BITS-1:0] ds_r;
    logic [VALUE_BITS-1:0] ds_acc;
    logic [PROD_W-1:0]     prod;
    logic                  af_bad;
    logic                  ds_term;
    logic                  ds_ok;
    logic [COUNT_BITS-1:0] pos_adv;
    logic [VALUE_BITS-1:0] value;

    // restart drops the conversion before this character is looked at
    assign s = i_item.restart ? STATE_RESET : i_state;
    assign c = i_item.character;
    assign d = digit_of(c);

    // decode: which action this character takes
    always_comb begin
        path    = P_BLANK;
        x_phase = PH_DIGITS;
        af_r    = i_radix;
        ds_r    = s.active_radix;
        ds_acc  = s.acc;
        case (s.phase)
            PH_AUTO0: begin
                if (d == DIG_X) begin
                    path    = P_XCH;
                    x_phase = PH_AUTOX;
                end else begin
                    path   = P_DIGIT;
                    ds_r   = RADIX_OCT;
                    ds_acc = '0;
                end
            end
            PH_AUTOX: begin
                path = P_FIRST;
                af_r = RADIX_HEX;
            end
            PH_HEX0: begin
                if (d == DIG_X) begin
                    path    = P_XCH;
                    x_phase = PH_DIGITS;
                end else begin
                    path = P_DIGIT;
                end
            end
            PH_DIGITS: begin
                path = P_DIGIT;
            end
            default: begin
                // leading phase, sign phase and unused codes
                if (s.phase != PH_SIGN && (c == CH_SPACE || c == CH_TAB)) begin
                    path = P_BLANK;
                end else if (s.phase != PH_SIGN && (c == CH_PLUS || c == CH_MINUS)) begin
                    path = P_SIGNCH;
                end else if (i_radix == RADIX_AUTO) begin
                    if (d == DIG_ZERO) begin
                        path = P_AUTO_ZERO;
                    end else begin
                        path = P_FIRST;
                        af_r = RADIX_DEC;
                    end
                end else if (i_radix == RADIX_HEX && d == DIG_ZERO) begin
                    path = P_HEX_ZERO;
                end else begin
                    path = P_FIRST;
                end
            end
        endcase
    end

    // multiply-accumulate with overflow seen in the bits above the value
    assign prod    = PROD_W'(ds_acc) * PROD_W'(ds_r) + PROD_W'(d);
    assign ds_term = (d == DIG_NONE);
    assign ds_ok   = (ds_r != '0) && (d < CHAR_BITS'(ds_r))
                     && (prod[PROD_W-1:VALUE_BITS] == '0);
    assign af_bad  = (af_r == '0) || (d >= CHAR_BITS'(af_r));
    assign pos_adv = (s.position != {COUNT_BITS{1'b1}}) ? s.position + 1'b1 : s.position;
    assign value   = s.negative ? (VALUE_BITS'(0) - ds_acc) : ds_acc;

    // next state
    always_comb begin
        o_state = s;
        case (path)
            P_BLANK: begin
                o_state.position = pos_adv;
            end
            P_SIGNCH: begin
                o_state.negative = (c == CH_MINUS);
                o_state.position = pos_adv;
                o_state.phase    = PH_SIGN;
            end
            P_AUTO_ZERO: begin
                o_state.position = pos_adv;
                o_state.phase    = PH_AUTO0;
            end
            P_HEX_ZERO: begin
                o_state.active_radix = RADIX_HEX;
                o_state.acc          = '0;
                o_state.position     = pos_adv;
                o_state.phase        = PH_HEX0;
            end
            P_XCH: begin
                o_state.position = pos_adv;
                o_state.phase    = x_phase;
            end
            P_FIRST: begin
                if (af_bad) begin
                    o_state = STATE_RESET;
                end else begin
                    o_state.active_radix = af_r;
                    o_state.acc          = VALUE_BITS'(d);
                    o_state.position     = pos_adv;
                    o_state.phase        = PH_DIGITS;
                end
            end
            P_DIGIT: begin
                o_state.phase        = PH_DIGITS;
                o_state.active_radix = ds_r;
                if (ds_term) begin
                    o_state = STATE_RESET;
                end else if (ds_ok) begin
                    o_state.acc      = prod[VALUE_BITS-1:0];
                    o_state.position = pos_adv;
                end else begin
                    o_state.error_seen = 1'b1;
                    o_state.acc        = '0;
                    o_state.position   = pos_adv;
                end
            end
            default: begin
                o_state = s;
            end
        endcase
    end

    // result: invalid first digit, or terminator after digits
    always_comb begin
        o_emit   = 1'b0;
        o_result = '{number: '1, failed: 1'b1, consumed_length: '0};
        if (path == P_FIRST && af_bad) begin
            o_emit = 1'b1;
        end else if (path == P_DIGIT && ds_term) begin
            o_emit                   = 1'b1;
            o_result.number          = s.error_seen ? {VALUE_BITS{1'b1}} : value;
            o_result.failed          = s.error_seen;
            o_result.consumed_length = s.position;
        end
    end

endmodule

/* hw/rtl/radix_string_to_integer.sv */
// Top level of the streaming radix string to integer converter
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------
//  in      | i_in_valid / o_in_ready | i_in_item  (character, restart)
//  out     | o_out_valid/ i_out_ready| o_out_item (number, failed, length)
//  cfg     | i_cfg_valid/ o_cfg_ready| i_cfg_radix (6 bits)
//
// One character per cycle while the output is not stalled. An item is taken into
// the input register, then decoded, multiplied by the radix and accumulated from
// there, and its result passes through the result register to the output.
// Synchronous active-low reset clears the conversion state and sets radix 16.
// A stalled output only holds up a character that would give a new result.
module radix_string_to_integer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rstoi_pkg::t_in_item                 i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rstoi_pkg::t_out_item                o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rstoi_pkg::RADIX_BITS-1:0]    i_cfg_radix
);
    import rstoi_pkg::*;

    t_in_item              r_in;
    logic                  r_in_valid;
    t_state                r_state;
    t_state                n_state;
    logic [RADIX_BITS-1:0] r_radix;
    t_out_item             r_out;
    logic                  r_out_valid;
    logic                  step_emit;
    t_out_item             step_result;
    logic                  fire;

    rstoi_step u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_radix  (r_radix),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    // an item proceeds unless its result would land on a full output register
    assign fire        = r_in_valid && (!step_emit || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // conversion state and radix register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_radix <= RADIX_RESET;
        end else begin
            if (fire) begin
                r_state <= n_state;
            end
            if (i_cfg_valid) begin
                r_radix <= i_cfg_radix;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && step_emit) begin
            r_out <= step_result;
        end
    end

endmodule

/* hw/rtl/rstoi_checker.sv */
// Port-level checker for the radix string converter, bound to the top level
`include "radix_string_to_integer_assert.svh"

module rstoi_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  rstoi_pkg::t_in_item                 i_in_item,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  rstoi_pkg::t_out_item                o_out_item,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [rstoi_pkg::RADIX_BITS-1:0]    i_cfg_radix
);
    import rstoi_pkg::*;

    // a result waiting for its taker stays
    `RSTOI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid, "result dropped while stalled")

    // and keeps its payload
    `RSTOI_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        $stable(o_out_item), "result changed while stalled")

    // the input side only stalls behind a blocked result
    `RSTOI_ASSERT_SAME(a_in_stall, i_clk, i_rst_n, !o_in_ready,
        o_out_valid && !i_out_ready, "input stalled without output backpressure")

    // a failed conversion reports all-ones
    `RSTOI_ASSERT_SAME(a_fail_ones, i_clk, i_rst_n, o_out_valid && o_out_item.failed,
        o_out_item.number == {VALUE_BITS{1'b1}}, "failed result not all-ones")

endmodule

bind radix_string_to_integer rstoi_checker u_rstoi_checker (.*);

/* verif/radix_string_to_integer_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the streaming radix string to integer converter
module radix_string_to_integer_tb;
    import rstoi_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 55;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_MAX    = 10;

    localparam logic [VALUE_BITS-1:0] ALL_ONES = '1;
    localparam logic [COUNT_BITS-1:0] LEN_MAX  = '1;

    // kinds of rows in the directed table
    typedef enum logic [1:0] {
        ROW_CHAR   = 2'd0,  // result, if any, comes from the predictor
        ROW_RESULT = 2'd1,  // result typed into the row
        ROW_RADIX  = 2'd2   // radix register write
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CHAR_BITS-1:0]  character;
        logic                  restart;
        logic [RADIX_BITS-1:0] radix;
        t_out_item             result;
    } t_row;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [RADIX_BITS-1:0] cfg_radix = '0;

    // side info that travels with each item, seen only by the monitor
    t_row_kind             drv_kind   = ROW_CHAR;
    t_out_item             drv_result = '0;

    bit                    quiet       = 1'b0;
    int unsigned           items_sent  = 0;
    int unsigned           fail_count  = 0;
    int unsigned           cycle_count = 0;

    // predictor copy of the register and the conversion state
    logic [RADIX_BITS-1:0] mdl_radix = RADIX_RESET;
    t_phase                mdl_phase;
    logic [VALUE_BITS-1:0] mdl_acc;
    logic [RADIX_BITS-1:0] mdl_base;
    logic                  mdl_neg;
    logic                  mdl_err;
    logic [COUNT_BITS-1:0] mdl_pos;
    logic                  conv_done;
    t_out_item             conv_result;

    t_out_item             pending_numbers [$];
    t_row                  dir_rows [$];

    radix_string_to_integer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_radix (cfg_radix)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // value of an alphanumeric character, DIG_NONE otherwise
    function automatic logic [CHAR_BITS-1:0] char_value(input logic [CHAR_BITS-1:0] c);
        if (c >= CH_0 && c <= CH_9) return c - CH_0;
        if (c >= CH_UA && c <= CH_UZ) return c - CH_UA + 8'd10;
        if (c >= CH_LA && c <= CH_LZ) return c - CH_LA + 8'd10;
        return DIG_NONE;
    endfunction

    task automatic clear_conv();
        mdl_phase = PH_LEAD;
        mdl_acc   = '0;
        mdl_base  = '0;
        mdl_neg   = 1'b0;
        mdl_err   = 1'b0;
        mdl_pos   = '0;
    endtask

    // consumed length saturates
    task automatic bump_pos();
        if (mdl_pos != LEN_MAX) mdl_pos++;
    endtask

    task automatic finish_conv(input logic [VALUE_BITS-1:0] num, input logic fail,
                               input logic [COUNT_BITS-1:0] len);
        conv_result.number          = num;
        conv_result.failed          = fail;
        conv_result.consumed_length = len;
        conv_done                   = 1'b1;
        clear_conv();
    endtask

    // first real digit: must be below the base or the conversion fails at once
    task automatic start_digits(input logic [CHAR_BITS-1:0] d,
                                input logic [RADIX_BITS-1:0] base);
        mdl_base = base;
        if (base == '0 || d >= base) begin
            finish_conv(ALL_ONES, 1'b1, '0);
        end else begin
            mdl_acc   = VALUE_BITS'(d);
            mdl_phase = PH_DIGITS;
            bump_pos();
        end
    endtask

    // later digit, or the terminator
    task automatic next_digit(input logic [CHAR_BITS-1:0] d);
        logic [63:0]           grown;
        logic [VALUE_BITS-1:0] signed_val;
        if (d == DIG_NONE) begin
            signed_val = mdl_neg ? -mdl_acc : mdl_acc;
            if (mdl_err) finish_conv(ALL_ONES, 1'b1, mdl_pos);
            else finish_conv(signed_val, 1'b0, mdl_pos);
        end else begin
            grown = 64'(mdl_acc) * 64'(mdl_base) + 64'(d);
            if (mdl_base != '0 && d < mdl_base && grown <= 64'(ALL_ONES)) begin
                mdl_acc = grown[VALUE_BITS-1:0];
            end else begin
                mdl_err = 1'b1;
                mdl_acc = '0;
            end
            bump_pos();
        end
    endtask

    // first character after blanks and sign; radix register decides the base
    task automatic lead_digit(input logic [CHAR_BITS-1:0] d);
        if (mdl_radix == RADIX_AUTO) begin
            if (d == DIG_ZERO) begin
                mdl_phase = PH_AUTO0;
                bump_pos();
            end else begin
                start_digits(d, RADIX_DEC);
            end
        end else if (mdl_radix == RADIX_HEX && d == DIG_ZERO) begin
            mdl_base  = RADIX_HEX;
            mdl_acc   = '0;
            mdl_phase = PH_HEX0;
            bump_pos();
        end else begin
            start_digits(d, mdl_radix);
        end
    endtask

    // one accepted item through the predictor; sets conv_done on a result
    task automatic convert_char(input t_in_item it);
        logic [CHAR_BITS-1:0] d;
        d         = char_value(it.character);
        conv_done = 1'b0;
        if (it.restart) clear_conv();
        case (mdl_phase)
            PH_SIGN: lead_digit(d);
            PH_AUTO0: begin
                if (d == DIG_X) begin
                    mdl_phase = PH_AUTOX;
                    bump_pos();
                end else begin
                    mdl_base  = RADIX_OCT;
                    mdl_acc   = '0;
                    mdl_phase = PH_DIGITS;
                    next_digit(d);
                end
            end
            PH_AUTOX: start_digits(d, RADIX_HEX);
            PH_HEX0: begin
                mdl_phase = PH_DIGITS;
                if (d == DIG_X) bump_pos();
                else next_digit(d);
            end
            PH_DIGITS: next_digit(d);
            default: begin
                if (it.character == CH_SPACE || it.character == CH_TAB) begin
                    bump_pos();
                end else if (it.character == CH_MINUS || it.character == CH_PLUS) begin
                    mdl_neg   = (it.character == CH_MINUS);
                    mdl_phase = PH_SIGN;
                    bump_pos();
                end else begin
                    lead_digit(d);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on accepted items, check accepted results
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) mdl_radix = cfg_radix;
            if (in_valid && in_ready) begin
                convert_char(in_item);
                if (drv_kind == ROW_RESULT) pending_numbers.push_back(drv_result);
                else if (conv_done) pending_numbers.push_back(conv_result);
            end
            if (out_valid && out_ready) begin
                if (pending_numbers.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("unexpected result at %0t: number %h failed %0d length %0d",
                                 $time, out_item.number, out_item.failed,
                                 out_item.consumed_length);
                    fail_count++;
                end else begin
                    want = pending_numbers.pop_front();
                    if (out_item.number !== want.number || out_item.failed !== want.failed ||
                        out_item.consumed_length !== want.consumed_length) begin
                        if (fail_count < REPORT_MAX)
                            $display({"mismatch at %0t: expected number %h failed %0d ",
                                      "length %0d, got number %h failed %0d length %0d"},
                                     $time, want.number, want.failed, want.consumed_length,
                                     out_item.number, out_item.failed,
                                     out_item.consumed_length);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side stalls in bursts of random length
    // ------------------------------------------------------------------
    initial begin
        int unsigned low_left;
        low_left = 0;
        forever begin
            @(negedge clk);
            if (low_left == 0 && !quiet && $urandom_range(0, 5) == 0)
                low_left = $urandom_range(1, 5);
            if (low_left != 0) begin
                out_ready <= 1'b0;
                low_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers (entered and left at a falling edge)
    // ------------------------------------------------------------------
    task automatic send_char(input logic [CHAR_BITS-1:0] c, input logic rst,
                             input t_row_kind kind, input t_out_item res);
        int unsigned gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 5);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_item    <= '{character: c, restart: rst};
        drv_kind   <= kind;
        drv_result <= res;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    // radix write only once the block has drained
    task automatic write_radix(input logic [RADIX_BITS-1:0] r);
        in_valid <= 1'b0;
        while (pending_numbers.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_radix <= r;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CHAR_BITS-1:0] digit_char(input int unsigned v);
        if (v < 10) return CH_0 + CHAR_BITS'(v);
        return ($urandom_range(0, 1) ? CH_UA : CH_LA) + CHAR_BITS'(v - 10);
    endfunction

    // one random text: mostly a well-formed number, sometimes noise
    task automatic send_sequence(input logic [RADIX_BITS-1:0] r, input bit long_lead);
        logic [CHAR_BITS-1:0] text [$];
        logic [63:0]          mag;
        int unsigned          base;
        int unsigned          cut;
        int unsigned          n;
        string                punct;
        punct = ".,;:-+/)";
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) text.push_back(CHAR_BITS'($urandom_range(0, 255)));
        end else begin
            // blanks, then an optional sign
            if (long_lead) n = $urandom_range(250, 270);
            else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 3);
            else n = 0;
            repeat (n) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            case ($urandom_range(0, 3))
                0: text.push_back(CH_MINUS);
                1: text.push_back(CH_PLUS);
                default: ;
            endcase
            // magnitude, with the overflow boundary weighted in
            case ($urandom_range(0, 5))
                0: mag = 64'($urandom_range(0, 40));
                1: mag = 64'($urandom);
                2: mag = 64'(ALL_ONES) - 64'($urandom_range(0, 3));
                3: mag = 64'(ALL_ONES) + 64'($urandom_range(1, 40));
                4: mag = {$urandom, $urandom} >> $urandom_range(16, 48);
                default: mag = 64'($urandom_range(0, 65535));
            endcase
            // base and prefix
            base = r;
            if (r == RADIX_AUTO) begin
                case ($urandom_range(0, 2))
                    0: begin
                        base = RADIX_OCT;
                        text.push_back(CH_0);
                    end
                    1: begin
                        base = RADIX_HEX;
                        text.push_back(CH_0);
                        text.push_back($urandom_range(0, 1) ? "x" : "X");
                    end
                    default: base = RADIX_DEC;
                endcase
            end else if (r == RADIX_HEX && $urandom_range(0, 1) == 1) begin
                text.push_back(CH_0);
                text.push_back($urandom_range(0, 1) ? "x" : "X");
            end
            if (base < 2) begin
                n = $urandom_range(1, 3);
                repeat (n) text.push_back(digit_char($urandom_range(0, 35)));
            end else begin
                if (base > 36) base = 36;
                cut = text.size();
                do begin
                    text.insert(cut, digit_char(int'(mag % base)));
                    mag = mag / base;
                end while (mag != 0);
                // occasional stray digit, often out of range
                if ($urandom_range(0, 7) == 0)
                    text[$urandom_range(cut, text.size() - 1)] =
                        digit_char($urandom_range(0, 35));
            end
            // terminator
            case ($urandom_range(0, 5))
                0: text.push_back(CH_SPACE);
                1: text.push_back(CH_TAB);
                2: text.push_back(CHAR_BITS'($urandom_range(128, 255)));
                3: text.push_back(CHAR_BITS'($urandom_range(0, 31)));
                default: text.push_back(punct[$urandom_range(0, 7)]);
            endcase
        end
        foreach (text[i])
            send_char(text[i], ($urandom_range(0, 39) == 0), ROW_CHAR, '0);
    endtask

    // directed table helpers
    function automatic t_row chr_row(input logic [CHAR_BITS-1:0] c, input logic rst);
        t_row entry;
        entry           = '0;
        entry.kind      = ROW_CHAR;
        entry.character = c;
        entry.restart   = rst;
        return entry;
    endfunction

    function automatic t_row res_row(input logic [CHAR_BITS-1:0] c, input logic rst,
                                     input logic [VALUE_BITS-1:0] num, input logic fail,
                                     input logic [COUNT_BITS-1:0] len);
        t_row entry;
        entry                        = chr_row(c, rst);
        entry.kind                   = ROW_RESULT;
        entry.result.number          = num;
        entry.result.failed          = fail;
        entry.result.consumed_length = len;
        return entry;
    endfunction

    function automatic t_row cfg_row(input logic [RADIX_BITS-1:0] r);
        t_row entry;
        entry       = '0;
        entry.kind  = ROW_RADIX;
        entry.radix = r;
        return entry;
    endfunction

    // ------------------------------------------------------------------
    // Cycle limit
    // ------------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [RADIX_BITS-1:0] r;
        int unsigned           phase_start;
        clear_conv();
        conv_done   = 1'b0;
        conv_result = '0;

        dir_rows = '{
            // radix 16 after reset: bare 0x prefix, then a digit out of range for the base
            chr_row("0", 1'b1), chr_row("x", 1'b0),
            res_row(CH_SPACE, 1'b0, '0, 1'b0, 8'd2),
            res_row("g", 1'b0, ALL_ONES, 1'b1, '0),
            // auto: bad digit right after 0x, then octal
            cfg_row(RADIX_AUTO),
            chr_row("0", 1'b1), chr_row("x", 1'b0),
            res_row("z", 1'b0, ALL_ONES, 1'b1, '0),
            chr_row("0", 1'b0), chr_row("7", 1'b0), chr_row(8'hFF, 1'b0),
            // decimal with tab and minus sign
            cfg_row(RADIX_DEC),
            chr_row(CH_TAB, 1'b1), chr_row(CH_MINUS, 1'b0), chr_row("9", 1'b0),
            res_row(":", 1'b0, 32'hFFFF_FFF7, 1'b0, 8'd3),
            // base 36, restart in the middle of a conversion
            cfg_row(6'd36),
            chr_row(CH_PLUS, 1'b0), chr_row("Z", 1'b1), chr_row("z", 1'b0),
            chr_row("@", 1'b0),
            // base 1 only takes the digit 0, so a 1 fails at once
            cfg_row(6'd1),
            res_row("1", 1'b0, ALL_ONES, 1'b1, '0),
            // base 63 overflows on the sixth digit
            cfg_row(6'd63),
            chr_row("z", 1'b1), chr_row("z", 1'b0), chr_row("z", 1'b0),
            chr_row("z", 1'b0), chr_row("z", 1'b0), chr_row("z", 1'b0),
            res_row(CH_SPACE, 1'b0, ALL_ONES, 1'b1, 8'd6)
        };

        // synchronous reset, held low from time zero
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_RADIX) write_radix(dir_rows[k].radix);
            else send_char(dir_rows[k].character, dir_rows[k].restart, dir_rows[k].kind,
                           dir_rows[k].result);
        end

        // random phases, each under a fresh radix; the last one runs flat out
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiet = (p == RANDOM_PHASES - 1);
            case ($urandom_range(0, 9))
                0: r = RADIX_AUTO;
                1: r = RADIX_DEC;
                2: r = RADIX_HEX;
                3: r = RADIX_OCT;
                4: r = 6'd2;
                5: r = 6'd36;
                6: r = 6'd63;
                7: r = 6'd1;
                default: r = RADIX_BITS'($urandom_range(0, 63));
            endcase
            write_radix(r);
            phase_start = items_sent;
            // one long run of blanks can drive the length into saturation
            if (p == 1) send_sequence(r, 1'b1);
            while (items_sent - phase_start < PHASE_ITEMS) send_sequence(r, 1'b0);
        end

        // drain
        in_valid <= 1'b0;
        while (pending_numbers.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/rstoi_pkg.sv
hw/rtl/rstoi_step.sv
hw/rtl/radix_string_to_integer.sv
hw/rtl/rstoi_checker.sv
verif/radix_string_to_integer_tb.sv
